### sv/mic_pkg.sv
// Shared types and constants for the masked image correlation block.
// No dependencies; the design files other than mic_mul refer to it by scoped names.
`default_nettype none
package mic_pkg;

   // Fixed-point result: Q2.14, one is 2^14.
   localparam int Q_BITS = 15;
   localparam logic [Q_BITS-1:0] ONE_Q14 = 15'd16384;
   localparam int BIT_W = 4;
   // Trial factor (2q-1)^2 needs this many bits, and R carries the same shift.
   localparam int SQ_BITS = 30;

   // Snapshot queue between accumulator and finisher.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QLVL_W = 2;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_NSAA,
      BK_SASA,
      BK_NSBB,
      BK_SBSB,
      BK_CHECK,
      BK_NSAB,
      BK_SASB,
      BK_VAVB,
      BK_COVSQ,
      BK_TRY,
      BK_TEST,
      BK_SIGN,
      BK_RESP
   } bk_state_type;

endpackage
`default_nettype wire

### sv/mic_front.sv
// Accumulator front end: takes pixel pairs, keeps exact sums, and pushes a
// snapshot of the sums on the last pair of an image. Uses mic_pkg.
`default_nettype none
module mic_front #(
   parameter int MaxPixels = 1048576,
   parameter int PW = 16,
   parameter int CW = 21,
   parameter int SW = 37,
   parameter int QW = 53
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [15:0]               req_pixel_a,
   input  wire logic [15:0]               req_pixel_b,
   input  wire logic                      req_a_missing,
   input  wire logic                      req_b_missing,
   input  wire logic                      req_last_pair,
   input  wire logic [mic_pkg::QLVL_W-1:0] q_level,
   output logic                           push_valid,
   output logic [CW-1:0]                  snap_n,
   output logic [SW-1:0]                  snap_sa,
   output logic [SW-1:0]                  snap_sb,
   output logic [QW-1:0]                  snap_saa,
   output logic [QW-1:0]                  snap_sbb,
   output logic [QW-1:0]                  snap_sab
);

   logic            s1_go_ff, s1_go_in;
   logic            s1_use_ff, s1_last_ff;
   logic [PW-1:0]   s1_a_ff, s1_b_ff;
   logic [2*PW-1:0] s1_aa_ff, s1_bb_ff, s1_ab_ff;
   logic [PW-1:0]   a_m, b_m;
   logic [2*PW-1:0] aa_in, bb_in, ab_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [QW-1:0] saa_ff, saa_in, sbb_ff, sbb_in, sab_ff, sab_in;
   logic          add;

   // Leave room for every last pair already in flight.
   assign req_ready = ({1'b0, q_level} + {{mic_pkg::QLVL_W{1'b0}}, s1_go_ff & s1_last_ff})
                      < (mic_pkg::QLVL_W+1)'(mic_pkg::QUEUE_DEPTH);

   assign a_m   = req_pixel_a[PW-1:0];
   assign b_m   = req_pixel_b[PW-1:0];
   assign aa_in = {{PW{1'b0}}, a_m} * {{PW{1'b0}}, a_m};
   assign bb_in = {{PW{1'b0}}, b_m} * {{PW{1'b0}}, b_m};
   assign ab_in = {{PW{1'b0}}, a_m} * {{PW{1'b0}}, b_m};
   assign s1_go_in = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_go_ff <= 1'b0;
      end else begin
         s1_go_ff <= s1_go_in;
      end
      s1_use_ff  <= ~(req_a_missing | req_b_missing);
      s1_last_ff <= req_last_pair;
      s1_a_ff    <= a_m;
      s1_b_ff    <= b_m;
      s1_aa_ff   <= aa_in;
      s1_bb_ff   <= bb_in;
      s1_ab_ff   <= ab_in;
   end

   // Pairs past the count limit are dropped until the image ends.
   assign add = s1_go_ff & s1_use_ff & (cnt_ff < CW'(MaxPixels));

   always_comb begin
      snap_n   = cnt_ff + CW'(add);
      snap_sa  = sa_ff + (add ? SW'(s1_a_ff) : '0);
      snap_sb  = sb_ff + (add ? SW'(s1_b_ff) : '0);
      snap_saa = saa_ff + (add ? QW'(s1_aa_ff) : '0);
      snap_sbb = sbb_ff + (add ? QW'(s1_bb_ff) : '0);
      snap_sab = sab_ff + (add ? QW'(s1_ab_ff) : '0);
      push_valid = s1_go_ff & s1_last_ff;
      if (push_valid) begin
         cnt_in = '0;
         sa_in  = '0;
         sb_in  = '0;
         saa_in = '0;
         sbb_in = '0;
         sab_in = '0;
      end else begin
         cnt_in = snap_n;
         sa_in  = snap_sa;
         sb_in  = snap_sb;
         saa_in = snap_saa;
         sbb_in = snap_sbb;
         sab_in = snap_sab;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sa_ff  <= '0;
         sb_ff  <= '0;
         saa_ff <= '0;
         sbb_ff <= '0;
         sab_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sa_ff  <= sa_in;
         sb_ff  <= sb_in;
         saa_ff <= saa_in;
         sbb_ff <= sbb_in;
         sab_ff <= sab_in;
      end
   end

endmodule
`default_nettype wire

### sv/mic_queue.sv
// Short snapshot queue between the accumulator and the finisher.
// Depth and pointer widths come from mic_pkg.
`default_nettype none
module mic_queue #(
   parameter int W = 254
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [W-1:0]               wr_data,
   input  wire logic                       pop,
   output logic                            rd_valid,
   output logic [W-1:0]                    rd_data,
   output logic [mic_pkg::QLVL_W-1:0]      level
);

   logic [W-1:0]                 mem_ff [mic_pkg::QUEUE_DEPTH];
   logic [mic_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mic_pkg::QLVL_W-1:0]   lvl_ff, lvl_in;

   assign rd_valid = (lvl_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign level    = lvl_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      lvl_in    = lvl_ff + mic_pkg::QLVL_W'(push) - mic_pkg::QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         lvl_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         lvl_ff    <= lvl_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

### sv/mic_mul.sv
// Shift-add multiplier for wide unsigned operands, one multiplier bit a
// cycle, stopping early once the remaining bits are zero. No package use.
`default_nettype none
module mic_mul #(
   parameter int XW = 148,
   parameter int YW = 74
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [XW-1:0]      op_x,
   input  wire logic [YW-1:0]      op_y,
   output logic                    done,
   output logic [XW+YW-1:0]        prod
);

   logic              busy_ff, busy_in;
   logic [XW+YW-1:0]  x_ff, x_in, acc_ff, acc_in;
   logic [YW-1:0]     y_ff, y_in;

   assign done = busy_ff & (y_ff == '0);
   assign prod = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = (XW+YW)'(op_x);
         y_in    = op_y;
         acc_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = y_ff[0] ? acc_ff + x_ff : acc_ff;
         x_in   = x_ff << 1;
         y_in   = y_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

### sv/mic_back.sv
// Finisher: pops a snapshot of sums, forms variances and covariance exactly,
// and finds the Q2.14 coefficient bit by bit. Uses mic_pkg and mic_mul.
`default_nettype none
module mic_back #(
   parameter int CW = 21,
   parameter int SW = 37,
   parameter int QW = 53
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_pop,
   input  wire logic [CW-1:0]        q_n,
   input  wire logic [SW-1:0]        q_sa,
   input  wire logic [SW-1:0]        q_sb,
   input  wire logic [QW-1:0]        q_saa,
   input  wire logic [QW-1:0]        q_sbb,
   input  wire logic [QW-1:0]        q_sab,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [15:0]        rsp_correlation,
   output logic                      rsp_status
);

   localparam int VW = CW + QW;
   localparam int XW = 2 * VW;
   localparam int YW = (VW > mic_pkg::SQ_BITS) ? VW : mic_pkg::SQ_BITS;
   localparam int PRW = XW + YW;
   localparam int RW = XW + mic_pkg::SQ_BITS;

   mic_pkg::bk_state_type state_ff, state_in;
   logic                  started_ff, started_in;

   logic [CW-1:0]  n_ff, n_in;
   logic [SW-1:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [QW-1:0]  saa_ff, saa_in, sbb_ff, sbb_in, sab_ff, sab_in;
   logic [VW-1:0]  t1_ff, t1_in, va_ff, va_in, vb_ff, vb_in, cov_ff, cov_in;
   logic           neg_ff, neg_in;
   logic [XW-1:0]  v_ff, v_in;
   logic [RW-1:0]  r_ff, r_in;
   logic [mic_pkg::Q_BITS-1:0] q_ff, q_in, t_ff, t_in, t_try;
   logic [mic_pkg::BIT_W-1:0]  bit_ff, bit_in;
   logic [mic_pkg::SQ_BITS-1:0] sq_ff, sq_in;
   logic [15:0]    odd, mag;
   logic [15:0]    res_ff, res_in;
   logic           status_ff, status_in;

   logic           mul_go, mul_done;
   logic [XW-1:0]  mul_x;
   logic [YW-1:0]  mul_y;
   logic [PRW-1:0] mul_p;
   logic [VW-1:0]  p_lo;

   mic_mul #(.XW(XW), .YW(YW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go),
      .op_x  (mul_x),
      .op_y  (mul_y),
      .done  (mul_done),
      .prod  (mul_p)
   );

   assign p_lo            = mul_p[VW-1:0];
   assign rsp_valid       = (state_ff == mic_pkg::BK_RESP);
   assign rsp_correlation = $signed(res_ff);
   assign rsp_status      = status_ff;
   assign t_try           = q_ff | (mic_pkg::Q_BITS'(1) << bit_ff);
   assign odd             = {t_try, 1'b0} - 16'd1;
   assign mag             = {1'b0, q_ff};

   // Operand select for the shared multiplier.
   always_comb begin
      case (state_ff)
         mic_pkg::BK_NSAA: begin mul_x = XW'(saa_ff); mul_y = YW'(n_ff);  end
         mic_pkg::BK_SASA: begin mul_x = XW'(sa_ff);  mul_y = YW'(sa_ff); end
         mic_pkg::BK_NSBB: begin mul_x = XW'(sbb_ff); mul_y = YW'(n_ff);  end
         mic_pkg::BK_SBSB: begin mul_x = XW'(sb_ff);  mul_y = YW'(sb_ff); end
         mic_pkg::BK_NSAB: begin mul_x = XW'(sab_ff); mul_y = YW'(n_ff);  end
         mic_pkg::BK_SASB: begin mul_x = XW'(sa_ff);  mul_y = YW'(sb_ff); end
         mic_pkg::BK_VAVB: begin mul_x = XW'(va_ff);  mul_y = YW'(vb_ff); end
         mic_pkg::BK_COVSQ: begin mul_x = XW'(cov_ff); mul_y = YW'(cov_ff); end
         mic_pkg::BK_TEST: begin mul_x = v_ff;         mul_y = YW'(sq_ff); end
         default: begin mul_x = '0; mul_y = '0; end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      n_in = n_ff; sa_in = sa_ff; sb_in = sb_ff;
      saa_in = saa_ff; sbb_in = sbb_ff; sab_in = sab_ff;
      t1_in = t1_ff; va_in = va_ff; vb_in = vb_ff; cov_in = cov_ff;
      neg_in = neg_ff; v_in = v_ff; r_in = r_ff;
      q_in = q_ff; t_in = t_ff; bit_in = bit_ff; sq_in = sq_ff;
      res_in = res_ff; status_in = status_ff;
      q_pop  = 1'b0;
      mul_go = 1'b0;
      case (state_ff)
         mic_pkg::BK_IDLE: begin
            started_in = 1'b0;
            if (q_valid) begin
               q_pop = 1'b1;
               n_in = q_n; sa_in = q_sa; sb_in = q_sb;
               saa_in = q_saa; sbb_in = q_sbb; sab_in = q_sab;
               if (q_n == '0) begin
                  res_in    = '0;
                  status_in = 1'b1;
                  state_in  = mic_pkg::BK_RESP;
               end else begin
                  state_in = mic_pkg::BK_NSAA;
               end
            end
         end
         mic_pkg::BK_CHECK: begin
            status_in = 1'b0;
            if (va_ff == '0 && vb_ff == '0) begin
               res_in   = 16'(mic_pkg::ONE_Q14);
               state_in = mic_pkg::BK_RESP;
            end else if (va_ff == '0 || vb_ff == '0) begin
               res_in   = '0;
               state_in = mic_pkg::BK_RESP;
            end else begin
               state_in = mic_pkg::BK_NSAB;
            end
         end
         mic_pkg::BK_TRY: begin
            // Skip trial values above one; otherwise form (2t-1)^2.
            if (t_try > mic_pkg::ONE_Q14) begin
               if (bit_ff == '0) begin
                  state_in = mic_pkg::BK_SIGN;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end else begin
               t_in     = t_try;
               sq_in    = odd[14:0] * odd[14:0];
               state_in = mic_pkg::BK_TEST;
            end
         end
         mic_pkg::BK_SIGN: begin
            res_in    = neg_ff ? 16'd0 - mag : mag;
            status_in = 1'b0;
            state_in  = mic_pkg::BK_RESP;
         end
         mic_pkg::BK_RESP: begin
            if (rsp_ready) begin
               state_in = mic_pkg::BK_IDLE;
            end
         end
         default: begin
            // Multiply steps: launch, then wait and capture.
            if (!started_ff) begin
               mul_go     = 1'b1;
               started_in = 1'b1;
            end else if (mul_done) begin
               started_in = 1'b0;
               case (state_ff)
                  mic_pkg::BK_NSAA: begin
                     t1_in = p_lo; state_in = mic_pkg::BK_SASA;
                  end
                  mic_pkg::BK_SASA: begin
                     va_in = (t1_ff > p_lo) ? t1_ff - p_lo : '0;
                     state_in = mic_pkg::BK_NSBB;
                  end
                  mic_pkg::BK_NSBB: begin
                     t1_in = p_lo; state_in = mic_pkg::BK_SBSB;
                  end
                  mic_pkg::BK_SBSB: begin
                     vb_in = (t1_ff > p_lo) ? t1_ff - p_lo : '0;
                     state_in = mic_pkg::BK_CHECK;
                  end
                  mic_pkg::BK_NSAB: begin
                     t1_in = p_lo; state_in = mic_pkg::BK_SASB;
                  end
                  mic_pkg::BK_SASB: begin
                     neg_in   = t1_ff < p_lo;
                     cov_in   = (t1_ff < p_lo) ? p_lo - t1_ff : t1_ff - p_lo;
                     state_in = mic_pkg::BK_VAVB;
                  end
                  mic_pkg::BK_VAVB: begin
                     v_in = mul_p[XW-1:0]; state_in = mic_pkg::BK_COVSQ;
                  end
                  mic_pkg::BK_COVSQ: begin
                     r_in     = {mul_p[XW-1:0], {mic_pkg::SQ_BITS{1'b0}}};
                     q_in     = '0;
                     bit_in   = mic_pkg::BIT_W'(mic_pkg::Q_BITS - 1);
                     state_in = mic_pkg::BK_TRY;
                  end
                  mic_pkg::BK_TEST: begin
                     if (mul_p <= PRW'(r_ff)) begin
                        q_in = t_ff;
                     end
                     if (bit_ff == '0) begin
                        state_in = mic_pkg::BK_SIGN;
                     end else begin
                        bit_in   = bit_ff - 1'b1;
                        state_in = mic_pkg::BK_TRY;
                     end
                  end
                  default: begin
                     state_in = mic_pkg::BK_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mic_pkg::BK_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
      n_ff <= n_in; sa_ff <= sa_in; sb_ff <= sb_in;
      saa_ff <= saa_in; sbb_ff <= sbb_in; sab_ff <= sab_in;
      t1_ff <= t1_in; va_ff <= va_in; vb_ff <= vb_in; cov_ff <= cov_in;
      neg_ff <= neg_in; v_ff <= v_in; r_ff <= r_in;
      q_ff <= q_in; t_ff <= t_in; bit_ff <= bit_in; sq_ff <= sq_in;
      res_ff <= res_in; status_ff <= status_in;
   end

endmodule
`default_nettype wire

### sv/masked_image_correlation.sv
// Masked image correlation, top level.
//
// req_ channel: one pixel pair per item (pixel_a, pixel_b, a_missing,
// b_missing, last_pair). A pair with either pixel missing is skipped.
// The accumulator takes one pair every cycle while req_ready is high and
// keeps exact sums; on the pair marked last it hands a snapshot of the
// sums to a two-entry queue and starts the next image from zero.
// rsp_ channel: one item per image, correlation in signed Q2.14 and
// status (1 when the image had no usable pair).
// The finisher runs on one shared shift-add multiplier, one multiplier
// bit a cycle, for eight wide products plus up to fifteen trial
// products per image, and then waits for the response to be taken.
// Throughput: one pair per cycle within an image; up to two finished
// images wait in the queue, after which req_ready drops until the
// finisher frees a slot.
// A stalled rsp_ready holds the result and the finisher; the front keeps
// accepting pairs until the queue fills.
// Reset clears all sums, the queue and the finisher state.
`default_nettype none
module masked_image_correlation #(
   parameter int MAX_PIXELS = 1048576,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [15:0]   req_pixel_a,
   input  wire logic [15:0]   req_pixel_b,
   input  wire logic          req_a_missing,
   input  wire logic          req_b_missing,
   input  wire logic          req_last_pair,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic signed [15:0] rsp_correlation,
   output logic               rsp_status
);

   // Only the low bits of each sample take part, at most 16.
   localparam int PW = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int SW = CW + PW;
   localparam int QW = CW + 2 * PW;
   localparam int EW = CW + 2 * SW + 3 * QW;

   logic                          push_valid;
   logic [CW-1:0]                 snap_n, q_n;
   logic [SW-1:0]                 snap_sa, snap_sb, q_sa, q_sb;
   logic [QW-1:0]                 snap_saa, snap_sbb, snap_sab, q_saa, q_sbb, q_sab;
   logic [EW-1:0]                 rd_data;
   logic                          q_valid, q_pop;
   logic [mic_pkg::QLVL_W-1:0]    q_level;

   mic_front #(
      .MaxPixels (MAX_PIXELS),
      .PW        (PW),
      .CW        (CW),
      .SW        (SW),
      .QW        (QW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_a   (req_pixel_a),
      .req_pixel_b   (req_pixel_b),
      .req_a_missing (req_a_missing),
      .req_b_missing (req_b_missing),
      .req_last_pair (req_last_pair),
      .q_level       (q_level),
      .push_valid    (push_valid),
      .snap_n        (snap_n),
      .snap_sa       (snap_sa),
      .snap_sb       (snap_sb),
      .snap_saa      (snap_saa),
      .snap_sbb      (snap_sbb),
      .snap_sab      (snap_sab)
   );

   // Hold finished-image sums until the finisher is free.
   mic_queue #(.W(EW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .wr_data  ({snap_n, snap_sa, snap_sb, snap_saa, snap_sbb, snap_sab}),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_data  (rd_data),
      .level    (q_level)
   );

   assign {q_n, q_sa, q_sb, q_saa, q_sbb, q_sab} = rd_data;

   mic_back #(
      .CW (CW),
      .SW (SW),
      .QW (QW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_n             (q_n),
      .q_sa            (q_sa),
      .q_sb            (q_sb),
      .q_saa           (q_saa),
      .q_sbb           (q_sbb),
      .q_sab           (q_sab),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_correlation (rsp_correlation),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire

### test/masked_image_correlation_check.sv
// Checker for the masked image correlation block: watches the pixel and
// result channels, predicts each image's correlation and compares.
// Depends only on the block's port list; no package types are needed.
module masked_image_correlation_check #(
   parameter int MAX_PIXELS = 1048576,
   parameter int PIXEL_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [15:0]        req_pixel_a,
   input  logic [15:0]        req_pixel_b,
   input  logic               req_a_missing,
   input  logic               req_b_missing,
   input  logic               req_last_pair,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_correlation,
   input  logic               rsp_status,
   output int                 failures,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] corr;
      logic               status;
   } corr_result_type;

   localparam int PB = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
   localparam logic [15:0] PIX_MASK = 16'((32'd1 << PB) - 1);

   corr_result_type expected_corr[$];
   logic [63:0] pair_count, acc_a, acc_b, acc_aa, acc_bb, acc_ab;

   assign pending = expected_corr.size();

   // n*s2 - s1*s1, floored at zero
   function automatic logic [255:0] spread_of(logic [63:0] n, s1, s2);
      logic [255:0] x, y;
      x = 256'(n) * 256'(s2);
      y = 256'(s1) * 256'(s1);
      return (x > y) ? x - y : '0;
   endfunction

   function automatic corr_result_type pearson_q14();
      corr_result_type r;
      logic [255:0] va, vb, x, y, cov, lhs_base, rhs, lhs;
      logic         neg;
      logic [31:0]  lo, hi, mid;
      logic [63:0]  odd;
      r.status = 1'b0;
      va = spread_of(pair_count, acc_a, acc_aa);
      vb = spread_of(pair_count, acc_b, acc_bb);
      if (va == 0 && vb == 0) begin
         r.corr = 16'sd16384;
         return r;
      end
      if (va == 0 || vb == 0) begin
         r.corr = '0;
         return r;
      end
      x = 256'(pair_count) * 256'(acc_ab);
      y = 256'(acc_a) * 256'(acc_b);
      neg = x < y;
      cov = neg ? y - x : x - y;
      lhs_base = va * vb;
      rhs = (cov * cov) << 30;
      lo = 0;
      hi = 16384;
      // largest q with (2q-1)^2 * va*vb <= 2^30 * cov^2
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 2 * 64'(mid) - 1;
         lhs = 256'(odd * odd) * lhs_base;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (lo > 16384) lo = 16384;
      r.corr = neg ? 16'(17'h10000 - lo) : 16'(lo);
      return r;
   endfunction

   always @(posedge clock) begin
      corr_result_type got, want;
      logic [63:0]  a, b;
      int           nerr;
      nerr = 0;
      if (reset) begin
         pair_count = '0; acc_a = '0; acc_b = '0;
         acc_aa = '0; acc_bb = '0; acc_ab = '0;
         failures <= 0;
         expected_corr.delete();
      end else begin
         if (req_valid && req_ready) begin
            a = 64'(req_pixel_a & PIX_MASK);
            b = 64'(req_pixel_b & PIX_MASK);
            // blocking updates so the last pair sees its own contribution
            if (!(req_a_missing || req_b_missing) && pair_count < MAX_PIXELS) begin
               pair_count = pair_count + 1;
               acc_a = acc_a + a;
               acc_b = acc_b + b;
               acc_aa = acc_aa + a * a;
               acc_bb = acc_bb + b * b;
               acc_ab = acc_ab + a * b;
            end
            if (req_last_pair) begin
               if (pair_count == 0) begin
                  want.corr = '0;
                  want.status = 1'b1;
               end else begin
                  want = pearson_q14();
               end
               expected_corr.push_back(want);
               pair_count = 0; acc_a = 0; acc_b = 0;
               acc_aa = 0; acc_bb = 0; acc_ab = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.corr = rsp_correlation;
            got.status = rsp_status;
            if (expected_corr.size() == 0) begin
               $error("result with nothing expected: correlation %0d status %0d",
                      got.corr, got.status);
               nerr = nerr + 1;
            end else begin
               want = expected_corr.pop_front();
               if (got.corr !== want.corr) begin
                  $error("correlation: expected %0d, actual %0d", want.corr, got.corr);
                  nerr = nerr + 1;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  nerr = nerr + 1;
               end
            end
         end
         failures <= failures + nerr;
      end
   end
endmodule

### test/masked_image_correlation_test.sv
// Testbench top for the masked image correlation block: drives pixel
// pairs image by image, stalls the result side, and gives the verdict.
// Depends on masked_image_correlation and masked_image_correlation_check.
module masked_image_correlation_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_pixel_a = '0;
   logic [15:0]        req_pixel_b = '0;
   logic               req_a_missing = 1'b0;
   logic               req_b_missing = 1'b0;
   logic               req_last_pair = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_correlation;
   logic               rsp_status;
   int                 failures;
   int                 pending;
   // idle percentage for both sides; zero during the steady stretch
   int                 idle_pct = 7;

   always #5 clock = ~clock;

   masked_image_correlation dut (.*);
   masked_image_correlation_check check (.*);

   // Random stall on the result side; re-rolled every cycle.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // Drive one pair, idling at random first, and hold it until accepted.
   // req_ready only moves at the rising edge, so its value at the falling
   // edge is the one seen by the next rising edge.
   task automatic send_pair(logic [15:0] a, logic [15:0] b,
                            logic am, logic bm, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_a <= a;
      req_pixel_b <= b;
      req_a_missing <= am;
      req_b_missing <= bm;
      req_last_pair <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Random image: small size, pixels related by a random style so that
   // correlations spread over the whole range, some pairs flagged missing.
   task automatic send_image(int len);
      int style, miss_pct, k;
      logic [15:0] a, b;
      style = $urandom_range(4);
      miss_pct = $urandom_range(3) * 10;
      for (k = 0; k < len; k++) begin
         a = 16'($urandom);
         case (style)
            0: b = 16'($urandom);
            1: b = a ^ 16'($urandom_range(255));
            2: b = ~a ^ 16'($urandom_range(255));
            3: b = 16'($urandom_range(1)) ? 16'hFFFF : 16'h0000;
            default: begin
               a = 16'($urandom_range(3));
               b = 16'($urandom_range(3));
            end
         endcase
         send_pair(a, b, $urandom_range(99) < miss_pct,
                   $urandom_range(99) < miss_pct, k == len - 1);
      end
   endtask

   initial begin
      int sent, i, len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: single pair, all pairs missing, both variances zero,
      // one variance zero, perfect positive and negative correlation,
      // field extremes.
      send_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
      send_pair(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0);
      send_pair(16'h1234, 16'h5678, 1'b0, 1'b1, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
      send_pair(16'd7, 16'd9, 1'b0, 1'b0, 1'b0);
      send_pair(16'd7, 16'd9, 1'b0, 1'b0, 1'b1);
      send_pair(16'd5, 16'h0000, 1'b0, 1'b0, 1'b0);
      send_pair(16'd5, 16'hFFFF, 1'b0, 1'b0, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
      send_pair(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
      send_pair(16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b0);
      send_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
      send_pair(16'd1, 16'd2, 1'b0, 1'b0, 1'b0);
      send_pair(16'd2, 16'd1, 1'b0, 1'b0, 1'b0);
      send_pair(16'd3, 16'd3, 1'b0, 1'b0, 1'b1);
      sent = 18;

      // Random images; drop idling entirely for a stretch in the middle.
      i = 0;
      while (sent < 1050) begin
         idle_pct = (i >= 40 && i < 70) ? 0 : 7;
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 60)
                                        : $urandom_range(1, 12);
         send_image(len);
         sent = sent + len;
         i++;
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) $display("PASS masked_image_correlation");
      else $display("FAIL masked_image_correlation");
      $finish;
   end

   // Timeout guard for the whole run: a few hundred images, with stalls.
   initial begin
      #20ms;
      $display("FAIL masked_image_correlation");
      $finish;
   end
endmodule
